// ===== hw/rtl/rys1d_pkg.sv =====
package rys1d_pkg;

    localparam int MAX_L     = 4;
    localparam int DIM       = MAX_L + 1;
    localparam int TBL_DEPTH = DIM * DIM;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);

    localparam int IDX_W  = 3;
    localparam int VAL_W  = 48;
    localparam int FRAC_W = 36;
    localparam int HALF_W = VAL_W / 2;
    localparam int PROD_W = 2 * VAL_W - 1;
    localparam int RM_W   = PROD_W - FRAC_W;
    localparam int M_W    = RM_W + 1;
    localparam int ACC_W  = M_W + 3;

    localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRAC_W;
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = IDX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MAX  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MAX = 1'd1;

    localparam logic [2:0] MUL_LAST = 3'd4;

    typedef enum logic [1:0] {
        XSEL_A,
        XSEL_B,
        XSEL_H
    } xsel_t;

    typedef struct packed {
        logic              load_in;
        logic              mem_rd;
        logic [ADDR_W-1:0] rd_addr;
        logic              mem_wr;
        logic              wr_one;
        logic [ADDR_W-1:0] wr_addr;
        logic              mag_load;
        xsel_t             xsel;
        logic [IDX_W-1:0]  coef;
        logic              mul_en;
        logic [2:0]        mul_step;
        logic              rnd_en;
        logic              scl_en;
        logic              acc_en;
        logic              acc_first;
        logic              out_load;
        logic [IDX_W-1:0]  out_row;
        logic [IDX_W-1:0]  out_col;
        logic              out_last;
    } rys1d_cmd_t;

    function automatic logic [ADDR_W-1:0] tbl_addr(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
        return ADDR_W'(int'(r) * DIM + int'(c));
    endfunction

    function automatic logic [IDX_W-1:0] clamp_idx(logic [IDX_W-1:0] v);
        return (int'(v) > MAX_L) ? IDX_W'(MAX_L) : v;
    endfunction

endpackage

// ===== hw/rtl/rys1d_ifs.sv =====
interface rys1d_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [rys1d_pkg::VAL_W-1:0] disp_a;
    logic signed [rys1d_pkg::VAL_W-1:0] disp_b;
    logic signed [rys1d_pkg::VAL_W-1:0] half_inv_exp;

    modport source (output valid, output disp_a, output disp_b, output half_inv_exp,
                    input ready);
    modport sink   (input valid, input disp_a, input disp_b, input half_inv_exp,
                    output ready);
endinterface

interface rys1d_out_if;
    logic                               valid;
    logic                               ready;
    logic        [rys1d_pkg::IDX_W-1:0] row_index;
    logic        [rys1d_pkg::IDX_W-1:0] col_index;
    logic signed [rys1d_pkg::VAL_W-1:0] entry_value;
    logic                               is_last;

    modport source (output valid, output row_index, output col_index, output entry_value,
                    output is_last, input ready);
    modport sink   (input valid, input row_index, input col_index, input entry_value,
                    input is_last, output ready);
endinterface

// ===== hw/rtl/rys_1d_recursion_table.sv =====
// Channel   Dir  Handshake     Payload
// operands  in   valid/ready   disp_a, disp_b, half_inv_exp (Q11.36)
// entries   out  valid/ready   row_index, col_index, entry_value, is_last
// cfg       in   cfg_we        cfg_index, cfg_data
//
// One table at a time. Each recurrence term runs on the shared 24x24
// multiplier (four partial products per Q11.36 product).
// Reset clears the sequencer, limits and output valid; table storage is not cleared.
// Entries stall while entries.ready is low; a new item is taken once the final
// entry sits in the output register.
module rys_1d_recursion_table (
    input  logic                                clk,
    input  logic                                rst_n,
    rys1d_in_if.sink                            operands,
    rys1d_out_if.source                         entries,
    input  logic                                cfg_we,
    input  logic [rys1d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rys1d_pkg::CFG_DATA_W-1:0]    cfg_data
);

    rys1d_pkg::rys1d_cmd_t cmd;
    logic                  out_free;

    rys1d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_free  (out_free),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd)
    );

    rys1d_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .disp_a       (operands.disp_a),
        .disp_b       (operands.disp_b),
        .half_inv_exp (operands.half_inv_exp),
        .out_ready    (entries.ready),
        .out_valid    (entries.valid),
        .row_index    (entries.row_index),
        .col_index    (entries.col_index),
        .entry_value  (entries.entry_value),
        .is_last      (entries.is_last),
        .out_free     (out_free)
    );

endmodule

// ===== hw/rtl/rys1d_dp.sv =====
module rys1d_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rys1d_pkg::rys1d_cmd_t               cmd,
    input  logic signed [rys1d_pkg::VAL_W-1:0]  disp_a,
    input  logic signed [rys1d_pkg::VAL_W-1:0]  disp_b,
    input  logic signed [rys1d_pkg::VAL_W-1:0]  half_inv_exp,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic        [rys1d_pkg::IDX_W-1:0]  row_index,
    output logic        [rys1d_pkg::IDX_W-1:0]  col_index,
    output logic signed [rys1d_pkg::VAL_W-1:0]  entry_value,
    output logic                                is_last,
    output logic                                out_free
);

    localparam int VAL_W  = rys1d_pkg::VAL_W;
    localparam int HALF_W = rys1d_pkg::HALF_W;
    localparam int PROD_W = rys1d_pkg::PROD_W;
    localparam int FRAC_W = rys1d_pkg::FRAC_W;
    localparam int RM_W   = rys1d_pkg::RM_W;
    localparam int M_W    = rys1d_pkg::M_W;
    localparam int ACC_W  = rys1d_pkg::ACC_W;
    localparam int IDX_W  = rys1d_pkg::IDX_W;
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_W - 1);

    logic [VAL_W-1:0] tbl_mem [rys1d_pkg::TBL_DEPTH];
    logic [VAL_W-1:0] rd_data_reg;

    logic signed [VAL_W-1:0] pa_reg;
    logic signed [VAL_W-1:0] pb_reg;
    logic signed [VAL_W-1:0] h_reg;

    logic [VAL_W-1:0]  mag_x_reg;
    logic [VAL_W-1:0]  mag_m_reg;
    logic              neg_reg;
    logic [IDX_W-1:0]  coef_reg;
    logic [2*HALF_W-1:0] pp_reg;
    logic [1:0]        pp_sh_reg;
    logic [PROD_W-1:0] prod_reg;
    logic signed [M_W-1:0]   m_reg;
    logic signed [ACC_W-1:0] scaled_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [IDX_W-1:0]        row_reg;
    logic [IDX_W-1:0]        col_reg;
    logic [VAL_W-1:0]        val_reg;
    logic                    last_reg;

    logic [VAL_W-1:0]        x_sel;
    logic [HALF_W-1:0]       a_half;
    logic [HALF_W-1:0]       b_half;
    logic [PROD_W-1:0]       pp_shifted;
    logic [PROD_W-1:0]       prod_rnd;
    logic [RM_W-1:0]         rm;
    logic signed [M_W-1:0]   m_next;
    logic signed [ACC_W-1:0] m_ext;
    logic signed [ACC_W-1:0] scaled_next;
    logic                    acc_fits;
    logic [VAL_W-1:0]        acc_sat;
    logic [VAL_W-1:0]        wr_data;

    function automatic logic [VAL_W-1:0] mag(logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
    endfunction

    always_comb
    begin
        case (cmd.xsel)
            rys1d_pkg::XSEL_A: x_sel = pa_reg;
            rys1d_pkg::XSEL_B: x_sel = pb_reg;
            default:           x_sel = h_reg;
        endcase
    end

    assign a_half = cmd.mul_step[1] ? mag_x_reg[VAL_W-1:HALF_W] : mag_x_reg[HALF_W-1:0];
    assign b_half = cmd.mul_step[0] ? mag_m_reg[VAL_W-1:HALF_W] : mag_m_reg[HALF_W-1:0];

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd1:    pp_shifted = PROD_W'(pp_reg) << HALF_W;
            default: pp_shifted = PROD_W'(pp_reg) << (2 * HALF_W);
        endcase
    end

    // round half away from zero on the magnitude
    assign prod_rnd = prod_reg + RND_HALF;
    assign rm       = prod_rnd[PROD_W-1:FRAC_W];
    assign m_next   = neg_reg ? -$signed(M_W'(rm)) : $signed(M_W'(rm));

    assign m_ext       = ACC_W'(m_reg);
    assign scaled_next = (coef_reg[0] ? m_ext : ACC_W'(0))
                       + (coef_reg[1] ? (m_ext <<< 1) : ACC_W'(0))
                       + (coef_reg[2] ? (m_ext <<< 2) : ACC_W'(0));

    assign acc_fits = (&acc_reg[ACC_W-1:VAL_W-1]) | ~(|acc_reg[ACC_W-1:VAL_W-1]);
    assign acc_sat  = acc_fits ? acc_reg[VAL_W-1:0]
                    : (acc_reg[ACC_W-1] ? rys1d_pkg::VAL_MIN : rys1d_pkg::VAL_MAX);
    assign wr_data  = cmd.wr_one ? rys1d_pkg::VAL_ONE : acc_sat;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            tbl_mem[cmd.wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= tbl_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pa_reg <= disp_a;
            pb_reg <= disp_b;
            h_reg  <= half_inv_exp;
        end
        if (cmd.mag_load)
        begin
            mag_x_reg <= mag(x_sel);
            mag_m_reg <= mag(rd_data_reg);
            neg_reg   <= x_sel[VAL_W-1] ^ rd_data_reg[VAL_W-1];
            coef_reg  <= cmd.coef;
            prod_reg  <= '0;
        end
        else if (cmd.mul_en && (cmd.mul_step != 3'd0))
        begin
            prod_reg <= prod_reg + pp_shifted;
        end
        if (cmd.mul_en)
        begin
            pp_reg    <= a_half * b_half;
            pp_sh_reg <= 2'(cmd.mul_step[1]) + 2'(cmd.mul_step[0]);
        end
        if (cmd.rnd_en)
        begin
            m_reg <= m_next;
        end
        if (cmd.scl_en)
        begin
            scaled_reg <= scaled_next;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= cmd.acc_first ? scaled_reg : acc_reg + scaled_reg;
        end
        if (cmd.out_load)
        begin
            row_reg  <= cmd.out_row;
            col_reg  <= cmd.out_col;
            val_reg  <= rd_data_reg;
            last_reg <= cmd.out_last;
        end
    end

    assign out_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_index   = row_reg;
    assign col_index   = col_reg;
    assign entry_value = val_reg;
    assign is_last     = last_reg;

endmodule

// ===== hw/rtl/rys1d_ctrl.sv =====
module rys1d_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 out_free,
    input  logic                                 cfg_we,
    input  logic [rys1d_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rys1d_pkg::CFG_DATA_W-1:0]     cfg_data,
    output rys1d_pkg::rys1d_cmd_t                cmd
);

    localparam int IDX_W = rys1d_pkg::IDX_W;
    localparam logic [1:0] T0 = 2'd0;
    localparam logic [1:0] T1 = 2'd1;
    localparam logic [1:0] T2 = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_NEXT,
        S_RD,
        S_MAG,
        S_MUL,
        S_RND,
        S_SCL,
        S_ACC,
        S_WR,
        S_ERD,
        S_ELD
    } state_t;

    typedef struct packed {
        logic                     ok;
        logic [IDX_W-1:0]         sr;
        logic [IDX_W-1:0]         sc;
        rys1d_pkg::xsel_t         xsel;
        logic [IDX_W-1:0]         coef;
    } term_t;

    state_t           state_reg,  state_next;
    logic [IDX_W-1:0] r_reg,      r_next;
    logic [IDX_W-1:0] c_reg,      c_next;
    logic [1:0]       t_reg,      t_next;
    logic [2:0]       step_reg,   step_next;
    logic [IDX_W-1:0] la_reg,     la_next;
    logic [IDX_W-1:0] lb_reg,     lb_next;
    logic [IDX_W-1:0] first_reg,  first_next;
    logic [IDX_W-1:0] second_reg, second_next;

    term_t info;
    term_t info1;
    term_t info2;
    logic  accept;
    logic  at_last;

    // source entry, operand and integer weight of each recurrence term
    function automatic term_t term_info(logic [1:0] t, logic [IDX_W-1:0] r,
                                        logic [IDX_W-1:0] c);
        term_t ti;
        ti = '0;
        case (t)
            T0:
            begin
                ti.ok   = 1'b1;
                ti.sr   = (c == 3'd0) ? r - 3'd1 : r;
                ti.sc   = (c == 3'd0) ? 3'd0 : c - 3'd1;
                ti.xsel = (c == 3'd0) ? rys1d_pkg::XSEL_A : rys1d_pkg::XSEL_B;
                ti.coef = 3'd1;
            end
            T1:
            begin
                ti.ok   = (c == 3'd0) ? (r >= 3'd2) : (r >= 3'd1);
                ti.sr   = (c == 3'd0) ? r - 3'd2 : r - 3'd1;
                ti.sc   = (c == 3'd0) ? 3'd0 : c - 3'd1;
                ti.xsel = rys1d_pkg::XSEL_H;
                ti.coef = (c == 3'd0) ? r - 3'd1 : r;
            end
            T2:
            begin
                ti.ok   = (c >= 3'd2);
                ti.sr   = r;
                ti.sc   = c - 3'd2;
                ti.xsel = rys1d_pkg::XSEL_H;
                ti.coef = c - 3'd1;
            end
            default:
            begin
                ti = '0;
            end
        endcase
        return ti;
    endfunction

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;
    assign info     = term_info(t_reg, r_reg, c_reg);
    assign info1    = term_info(T1, r_reg, c_reg);
    assign info2    = term_info(T2, r_reg, c_reg);
    assign at_last  = (r_reg == la_reg) && (c_reg == lb_reg);

    always_comb
    begin
        state_next  = state_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        t_next      = t_reg;
        step_next   = step_reg;
        la_next     = la_reg;
        lb_next     = lb_reg;
        first_next  = first_reg;
        second_next = second_reg;
        cmd         = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                rys1d_pkg::CFG_FIRST_MAX:  first_next  = cfg_data;
                rys1d_pkg::CFG_SECOND_MAX: second_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    la_next     = rys1d_pkg::clamp_idx(first_reg);
                    lb_next     = rys1d_pkg::clamp_idx(second_reg);
                    r_next      = '0;
                    c_next      = '0;
                    state_next  = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_one  = 1'b1;
                cmd.wr_addr = rys1d_pkg::tbl_addr(3'd0, 3'd0);
                state_next  = S_NEXT;
            end
            S_NEXT:
            begin
                t_next = T0;
                if (r_reg < la_reg)
                begin
                    r_next     = r_reg + 3'd1;
                    state_next = S_RD;
                end
                else if (c_reg < lb_reg)
                begin
                    c_next     = c_reg + 3'd1;
                    r_next     = '0;
                    state_next = S_RD;
                end
                else
                begin
                    r_next     = '0;
                    c_next     = '0;
                    state_next = S_ERD;
                end
            end
            S_RD:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.rd_addr = rys1d_pkg::tbl_addr(info.sr, info.sc);
                state_next  = S_MAG;
            end
            S_MAG:
            begin
                cmd.mag_load = 1'b1;
                cmd.xsel     = info.xsel;
                cmd.coef     = info.coef;
                step_next    = '0;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = step_reg;
                if (step_reg == rys1d_pkg::MUL_LAST)
                begin
                    state_next = S_RND;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            S_RND:
            begin
                cmd.rnd_en = 1'b1;
                state_next = S_SCL;
            end
            S_SCL:
            begin
                cmd.scl_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en    = 1'b1;
                cmd.acc_first = (t_reg == T0);
                if ((t_reg == T0) && info1.ok)
                begin
                    t_next     = T1;
                    state_next = S_RD;
                end
                else if ((t_reg != T2) && info2.ok)
                begin
                    t_next     = T2;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_addr = rys1d_pkg::tbl_addr(r_reg, c_reg);
                state_next  = S_NEXT;
            end
            S_ERD:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.rd_addr = rys1d_pkg::tbl_addr(r_reg, c_reg);
                state_next  = S_ELD;
            end
            S_ELD:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_row  = r_reg;
                    cmd.out_col  = c_reg;
                    cmd.out_last = at_last;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (c_reg < lb_reg)
                        begin
                            c_next = c_reg + 3'd1;
                        end
                        else
                        begin
                            c_next = '0;
                            r_next = r_reg + 3'd1;
                        end
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            r_reg      <= '0;
            c_reg      <= '0;
            t_reg      <= T0;
            step_reg   <= '0;
            la_reg     <= '0;
            lb_reg     <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            r_reg      <= r_next;
            c_reg      <= c_next;
            t_reg      <= t_next;
            step_reg   <= step_next;
            la_reg     <= la_next;
            lb_reg     <= lb_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> ((r_reg <= la_reg) && (c_reg <= lb_reg)))
        else $error("table index beyond latched limits");

    a_limits_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(la_reg) <= rys1d_pkg::MAX_L) && (int'(lb_reg) <= rys1d_pkg::MAX_L))
        else $error("latched limit above MAX_L");

    a_third_term_col: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> ((t_reg != T2) || (c_reg >= 3'd2)))
        else $error("second-index term issued in first two columns");

    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MUL) && (step_reg == rys1d_pkg::MUL_LAST)) |=> (state_reg == S_RND))
        else $error("product did not move to rounding");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_last) |=> (state_reg == S_IDLE))
        else $error("sequencer busy after final entry");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int               MAX_L      = rys1d_pkg::MAX_L;
    localparam int               IDX_W      = rys1d_pkg::IDX_W;
    localparam int               VAL_W      = rys1d_pkg::VAL_W;
    localparam int               FRAC_W     = rys1d_pkg::FRAC_W;
    localparam int               CFG_IDX_W  = rys1d_pkg::CFG_IDX_W;
    localparam int               CFG_DATA_W = rys1d_pkg::CFG_DATA_W;
    localparam logic [VAL_W-1:0] VAL_ONE    = rys1d_pkg::VAL_ONE;
    localparam logic [VAL_W-1:0] VAL_MAX    = rys1d_pkg::VAL_MAX;
    localparam logic [VAL_W-1:0] VAL_MIN    = rys1d_pkg::VAL_MIN;

    localparam int      CLK_PERIOD  = 20;
    localparam longint  CYCLE_LIMIT = 2_000_000;
    localparam int      N_PHASES    = 12;
    localparam int      PHASE_ITEMS = 30;
    localparam int      HOLD_CYCLES = 1500;

    localparam int PH_FIRST  [N_PHASES] = '{0, 4, 1, 0, 2, 7, 5, 3, 4, 0, 1, 3};
    localparam int PH_SECOND [N_PHASES] = '{0, 4, 0, 1, 3, 7, 2, 6, 0, 4, 1, 2};

    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             last;
    } table_entry_t;

    class rys_table_scoreboard;
        table_entry_t expected_entries[$];
        int unsigned  first_lim;
        int unsigned  second_lim;
        int           errors;

        function new();
            first_lim  = 0;
            second_lim = 0;
            errors     = 0;
        endfunction

        function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            if (idx == rys1d_pkg::CFG_FIRST_MAX)
                first_lim = v;
            else
                second_lim = v;
        endfunction

        function longint sat_value(longint x);
            longint hi;
            longint lo;
            hi = longint'(VAL_MAX);
            lo = -hi - 1;
            if (x > hi)
                return hi;
            if (x < lo)
                return lo;
            return x;
        endfunction

        // exact product, magnitude rounded half away from zero, no saturation
        function longint q_mul(longint a, longint b);
            logic [VAL_W-1:0] ma;
            logic [VAL_W-1:0] mb;
            logic [95:0]      p;
            longint           m;
            ma = VAL_W'(a < 0 ? -a : a);
            mb = VAL_W'(b < 0 ? -b : b);
            p  = 96'(ma) * 96'(mb);
            p  = p + (96'(1) << (FRAC_W - 1));
            m  = longint'(p >> FRAC_W);
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function void note_operands(logic signed [VAL_W-1:0] a,
                                    logic signed [VAL_W-1:0] b,
                                    logic signed [VAL_W-1:0] h);
            longint       tbl[MAX_L+1][MAX_L+1];
            longint       pa;
            longint       pb;
            longint       ph;
            longint       acc;
            int           la;
            int           lb;
            table_entry_t e;
            pa = a;
            pb = b;
            ph = h;
            la = (first_lim > MAX_L) ? MAX_L : int'(first_lim);
            lb = (second_lim > MAX_L) ? MAX_L : int'(second_lim);
            for (int i = 0; i <= MAX_L; i++)
                for (int j = 0; j <= MAX_L; j++)
                    tbl[i][j] = 0;
            tbl[0][0] = longint'(VAL_ONE);
            for (int i = 0; i < la; i++)
            begin
                acc = q_mul(pa, tbl[i][0]);
                if (i > 0)
                    acc += i * q_mul(ph, tbl[i-1][0]);
                tbl[i+1][0] = sat_value(acc);
            end
            for (int j = 0; j < lb; j++)
                for (int i = 0; i <= la; i++)
                begin
                    acc = q_mul(pb, tbl[i][j]);
                    if (i > 0)
                        acc += i * q_mul(ph, tbl[i-1][j]);
                    if (j > 0)
                        acc += j * q_mul(ph, tbl[i][j-1]);
                    tbl[i][j+1] = sat_value(acc);
                end
            for (int i = 0; i <= la; i++)
                for (int j = 0; j <= lb; j++)
                begin
                    e.row   = IDX_W'(i);
                    e.col   = IDX_W'(j);
                    e.value = VAL_W'(tbl[i][j]);
                    e.last  = (i == la) && (j == lb);
                    expected_entries.push_back(e);
                end
        endfunction

        function void check_entry(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                  logic [VAL_W-1:0] value, logic last);
            table_entry_t e;
            if (expected_entries.size() == 0)
            begin
                $error("unexpected entry row %0d col %0d value %h", row, col, value);
                errors++;
                return;
            end
            e = expected_entries.pop_front();
            if (row !== e.row)
            begin
                $error("row_index: expected %0d, got %0d", e.row, row);
                errors++;
            end
            if (col !== e.col)
            begin
                $error("col_index: expected %0d, got %0d", e.col, col);
                errors++;
            end
            if (value !== e.value)
            begin
                $error("entry_value: expected %h, got %h", e.value, value);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("is_last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_entries.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rys1d_in_if  op_if ();
    rys1d_out_if ent_if ();

    rys_1d_recursion_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .operands  (op_if),
        .entries   (ent_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rys_table_scoreboard sb = new();

    int     src_idle;
    int     snk_idle;
    bit     hold_request;
    int     hold_left;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("** rys_1d_recursion_table: FAILED **");
                $finish;
            end
        end
    end

    // entries side: ready changes on the falling edge, long hold-off on request
    initial
    begin
        ent_if.ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ent_if.ready <= 1'b0;
            end
            else
                ent_if.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && ent_if.valid && ent_if.ready)
                sb.check_entry(ent_if.row_index, ent_if.col_index,
                               ent_if.entry_value, ent_if.is_last);
        end
    end

    function automatic logic signed [VAL_W-1:0] rand_q();
        logic signed [VAL_W-1:0] r;
        r = VAL_W'({$urandom(), $urandom()});
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return r >>> 10;
            6, 7:             return r >>> 6;
            8:                return r;
            default:
                case ($urandom_range(4))
                    0:       return '0;
                    1:       return VAL_ONE;
                    2:       return -VAL_ONE;
                    3:       return VAL_MAX;
                    default: return VAL_MIN;
                endcase
        endcase
    endfunction

    task automatic send_operands(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b,
                                 logic signed [VAL_W-1:0] h);
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            op_if.valid <= 1'b0;
            @(negedge clk);
        end
        op_if.valid        <= 1'b1;
        op_if.disp_a       <= a;
        op_if.disp_b       <= b;
        op_if.half_inv_exp <= h;
        forever
        begin
            @(posedge clk);
            if (op_if.ready)
                break;
        end
        sb.note_operands(a, b, h);
    endtask

    task automatic stop_operands();
        @(negedge clk);
        op_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_limits(int first, int second);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= rys1d_pkg::CFG_FIRST_MAX;
        cfg_data  <= CFG_DATA_W'(first);
        @(posedge clk);
        sb.set_limit(rys1d_pkg::CFG_FIRST_MAX, CFG_DATA_W'(first));
        @(negedge clk);
        cfg_index <= rys1d_pkg::CFG_SECOND_MAX;
        cfg_data  <= CFG_DATA_W'(second);
        @(posedge clk);
        sb.set_limit(rys1d_pkg::CFG_SECOND_MAX, CFG_DATA_W'(second));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        localparam int ND = 13;
        logic signed [VAL_W-1:0] da [ND];
        logic signed [VAL_W-1:0] db [ND];
        logic signed [VAL_W-1:0] dh [ND];
        da = '{'0, VAL_ONE, -VAL_ONE, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN,
               48'sd1 << 18, 48'sd1 << 18, 48'sd1, 48'sd1 << 35, 48'sd2 << 36, VAL_ONE};
        db = '{'0, VAL_ONE, -VAL_ONE, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX,
               48'sd1 << 18, -(48'sd1 << 18), 48'sd1, 48'sd1 << 35, -(48'sd3 << 36), '0};
        dh = '{'0, VAL_ONE, -VAL_ONE, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN,
               48'sd1 << 17, -(48'sd1 << 17), 48'sd1, 48'sd1 << 34, 48'sd1 << 35, VAL_ONE};
        for (int k = 0; k < ND; k++)
            send_operands(da[k], db[k], dh[k]);
        stop_operands();
        wait_drained();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        op_if.valid        = 1'b0;
        op_if.disp_a       = '0;
        op_if.disp_b       = '0;
        op_if.half_inv_exp = '0;
        hold_request       = 1'b0;
        src_idle           = 22;
        snk_idle           = 46;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // defaults after reset: single-entry table
        send_operands(rand_q(), rand_q(), rand_q());
        stop_operands();
        wait_drained();

        write_limits(MAX_L, MAX_L);
        run_directed();

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p < 4)
            begin
                src_idle = 22;
                snk_idle = 46;
            end
            else if (p < 8)
            begin
                src_idle = 46;
                snk_idle = 22;
            end
            else
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            write_limits(PH_FIRST[p], PH_SECOND[p]);
            if (p == 2)
                hold_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_operands(rand_q(), rand_q(), rand_q());
            stop_operands();
            wait_drained();
        end

        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("** rys_1d_recursion_table: PASSED **");
        else
            $display("** rys_1d_recursion_table: FAILED **");
        $finish;
    end

endmodule
